// File: src/acc_alu_pkg.sv
// Shared types and operation codes for the accumulator integer ALU.
// Used by accumulator_integer_alu_top; depends on nothing else.
package acc_alu_pkg;

    // Operation codes carried in the cmd field.
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_MOD = 3'd4;
    localparam logic [2:0] CMD_POW = 3'd5;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    // One request word.
    typedef struct packed {
        logic [2:0]               cmd;
        logic                     use_accumulator;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } req_word_t;

    // One response word.
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     divide_by_zero;
    } rsp_word_t;

    // Two's complement magnitude of a signed word.
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        mag = x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

// File: src/accumulator_integer_alu_top.sv
// Accumulator integer ALU: sequencer around one shared multiplier and one
// restoring-divider subtract step. Depends on acc_alu_pkg.
//
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_stall | req_word_t
//  rsp     | out       | rsp_valid / rsp_stall | rsp_word_t
//
// Add, sub, mul and special cases pass the execute and finish states. Div
// and mod add 32 radix-2 subtract steps and a sign fix. Power adds a
// multiply and a squaring state for each exponent bit up to the highest set
// one, since the shared multiplier does one product a cycle.
// Reset clears the accumulator, the sequencer and the response valid.
// A new word is taken whenever the sequencer is idle, even while a response
// waits under stall; a finished result then waits until the register frees.
module accumulator_integer_alu_top
    import acc_alu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_EXEC    = 7'b0000010,
        ST_DIV     = 7'b0000100,
        ST_DFIX    = 7'b0001000,
        ST_POW_MUL = 7'b0010000,
        ST_POW_SQ  = 7'b0100000,
        ST_FIN     = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [DATA_W-1:0] left_reg, left_next;
    logic [DATA_W-1:0] opb_reg, opb_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] exp_reg, exp_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              dz_reg, dz_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_reg, rsp_next;

    logic [DATA_W-1:0] mul_x, mul_y, mul_res;
    logic [DATA_W:0]   rem_sh, diff;
    logic              rsp_free;

    // Shared multiplier; only the low word is kept.
    always_comb
    begin
        mul_x = left_reg;
        mul_y = opb_reg;
        if (state_reg == ST_POW_MUL)
        begin
            mul_x = prod_reg;
            mul_y = sq_reg;
        end
        else if (state_reg == ST_POW_SQ)
        begin
            mul_x = sq_reg;
            mul_y = sq_reg;
        end
    end

    assign mul_res = mul_x * mul_y;

    // One restoring-division step.
    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        left_next      = left_reg;
        opb_next       = opb_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        dz_next        = dz_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    left_next  = req.use_accumulator ? acc_reg : req.operand_a;
                    opb_next   = req.operand_b;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                dz_next    = 1'b0;
                res_next   = acc_reg;
                state_next = ST_FIN;
                case (cmd_reg)
                    CMD_ADD: res_next = left_reg + opb_reg;
                    CMD_SUB: res_next = left_reg - opb_reg;
                    CMD_MUL: res_next = mul_res;
                    CMD_DIV, CMD_MOD:
                    begin
                        if (opb_reg == '0)
                        begin
                            dz_next = 1'b1;
                        end
                        else
                        begin
                            quo_next   = mag(left_reg);
                            dvs_next   = mag(opb_reg);
                            rem_next   = '0;
                            cnt_next   = '1;
                            state_next = ST_DIV;
                        end
                    end
                    CMD_POW:
                    begin
                        if (opb_reg[DATA_W-1] || opb_reg == '0)
                        begin
                            res_next = DATA_W'(1);
                        end
                        else
                        begin
                            prod_next  = DATA_W'(1);
                            sq_next    = left_reg;
                            exp_next   = opb_reg;
                            state_next = ST_POW_MUL;
                        end
                    end
                    default: res_next = acc_reg;
                endcase
            end

            // Shift in one dividend bit and subtract where it fits.
            ST_DIV:
            begin
                quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
                rem_next = diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DFIX;
                end
            end

            // Quotient sign follows both operands, remainder the dividend.
            ST_DFIX:
            begin
                if (cmd_reg == CMD_DIV)
                begin
                    res_next = (left_reg[DATA_W-1] ^ opb_reg[DATA_W-1])
                             ? (~quo_reg + 1'b1) : quo_reg;
                end
                else
                begin
                    res_next = left_reg[DATA_W-1] ? (~rem_reg + 1'b1) : rem_reg;
                end
                state_next = ST_FIN;
            end

            ST_POW_MUL:
            begin
                if (exp_reg[0])
                begin
                    prod_next = mul_res;
                end
                state_next = ST_POW_SQ;
            end

            ST_POW_SQ:
            begin
                sq_next  = mul_res;
                exp_next = exp_reg >> 1;
                if ((exp_reg >> 1) == '0)
                begin
                    res_next   = prod_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_POW_MUL;
                end
            end

            // Hand the result over once the response register is free.
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_next.result_value   = res_reg;
                    rsp_next.divide_by_zero = dz_reg;
                    rsp_valid_next          = 1'b1;
                    acc_next                = res_reg;
                    state_next              = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        left_reg <= left_next;
        opb_reg  <= opb_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        exp_reg  <= exp_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        dz_reg   <= dz_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
